// ===== rtl/iclp_pkg.sv =====
package iclp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_CMD   = 3'd1,
        PH_ARGC  = 3'd2,
        PH_ARG   = 3'd3,
        PH_DELAY = 3'd4
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_DELAY = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    // Classified request passed from the parser to the output stage
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_entry;

    // Queue status seen by the parser and the output stage
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] DELAY_LONG_CODE = 8'd255;
    localparam logic [8:0] DELAY_LONG_MS   = 9'd500;

endpackage

// ===== rtl/iclp_front.sv =====
module iclp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_table_byte,
    input  iclp_pkg::t_q_status i_q_status,
    output logic              o_stall,
    output logic              o_push,
    output iclp_pkg::t_entry  o_entry
);
    import iclp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_cmds_left, n_cmds_left;
    logic [6:0] r_args_left, n_args_left;
    logic       r_delay_pending, n_delay_pending;

    logic       accept;
    logic [7:0] cmds_dec;
    logic [6:0] args_dec;
    logic       last_cmd;
    logic       last_arg;
    logic       emit;

    // Take a request whenever the queue has room
    assign o_stall  = i_q_status.full;
    assign accept   = i_valid && !i_q_status.full;
    assign cmds_dec = r_cmds_left - 8'd1;
    assign args_dec = r_args_left - 7'd1;
    assign last_cmd = (cmds_dec == 8'd0);
    assign last_arg = (args_dec == 7'd0);

    // Next state
    always_comb begin
        n_phase         = r_phase;
        n_cmds_left     = r_cmds_left;
        n_args_left     = r_args_left;
        n_delay_pending = r_delay_pending;
        case (r_phase)
            PH_CMD: begin
                n_phase = PH_ARGC;
            end
            PH_ARGC: begin
                n_args_left     = i_table_byte[6:0];
                n_delay_pending = i_table_byte[7];
                if (i_table_byte[6:0] != 7'd0) begin
                    n_phase = PH_ARG;
                end else if (i_table_byte[7]) begin
                    n_phase = PH_DELAY;
                end else begin
                    n_cmds_left = cmds_dec;
                    n_phase     = last_cmd ? PH_COUNT : PH_CMD;
                end
            end
            PH_ARG: begin
                n_args_left = args_dec;
                if (last_arg) begin
                    if (r_delay_pending) begin
                        n_phase = PH_DELAY;
                    end else begin
                        n_cmds_left = cmds_dec;
                        n_phase     = last_cmd ? PH_COUNT : PH_CMD;
                    end
                end
            end
            PH_DELAY: begin
                n_delay_pending = 1'b0;
                n_cmds_left     = cmds_dec;
                n_phase         = last_cmd ? PH_COUNT : PH_CMD;
            end
            default: begin
                n_cmds_left     = i_table_byte;
                n_args_left     = 7'd0;
                n_delay_pending = 1'b0;
                n_phase         = (i_table_byte == 8'd0) ? PH_COUNT : PH_CMD;
            end
        endcase
    end

    // Classify the byte into a request for the output stage
    always_comb begin
        emit         = 1'b0;
        o_entry.kind = KIND_END;
        o_entry.data = i_table_byte;
        o_entry.last = 1'b0;
        case (r_phase)
            PH_CMD: begin
                emit         = 1'b1;
                o_entry.kind = KIND_CMD;
            end
            PH_ARGC: begin
                emit         = (i_table_byte == 8'd0) && last_cmd;
                o_entry.kind = KIND_END;
                o_entry.last = 1'b1;
            end
            PH_ARG: begin
                emit         = 1'b1;
                o_entry.kind = KIND_DATA;
                o_entry.last = last_arg && !r_delay_pending && last_cmd;
            end
            PH_DELAY: begin
                emit         = 1'b1;
                o_entry.kind = KIND_DELAY;
                o_entry.last = last_cmd;
            end
            default: begin
                emit         = (i_table_byte == 8'd0);
                o_entry.kind = KIND_END;
                o_entry.last = 1'b1;
            end
        endcase
    end

    assign o_push = accept && emit;

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_COUNT;
            r_cmds_left     <= 8'd0;
            r_args_left     <= 7'd0;
            r_delay_pending <= 1'b0;
        end else if (accept) begin
            r_phase         <= n_phase;
            r_cmds_left     <= n_cmds_left;
            r_args_left     <= n_args_left;
            r_delay_pending <= n_delay_pending;
        end
    end

endmodule

// ===== rtl/iclp_queue.sv =====
module iclp_queue #(
    parameter int DEPTH = iclp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  iclp_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output iclp_pkg::t_entry    o_entry,
    output iclp_pkg::t_q_status o_status
);
    import iclp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/iclp_back.sv =====
module iclp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iclp_pkg::t_entry    i_entry,
    input  iclp_pkg::t_q_status i_q_status,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic [8:0]          o_wait_ms,
    output logic                o_list_last
);
    import iclp_pkg::*;

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_out_byte;
    logic [8:0] r_wait_ms;
    logic       r_list_last;

    logic [7:0] n_out_byte;
    logic [8:0] n_wait_ms;

    // Pop whenever the output register is free or being drained
    assign o_pop = !i_q_status.empty && (!r_valid || !i_stall);

    // Format the request: zero unused fields, map the long delay code
    always_comb begin
        n_out_byte = 8'd0;
        n_wait_ms  = 9'd0;
        case (i_entry.kind)
            KIND_CMD, KIND_DATA: begin
                n_out_byte = i_entry.data;
            end
            KIND_DELAY: begin
                n_wait_ms = (i_entry.data == DELAY_LONG_CODE) ? DELAY_LONG_MS
                                                              : {1'b0, i_entry.data};
            end
            default: begin
                n_out_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind      <= i_entry.kind;
            r_out_byte  <= n_out_byte;
            r_wait_ms   <= n_wait_ms;
            r_list_last <= i_entry.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_wait_ms   = r_wait_ms;
    assign o_list_last = r_list_last;

endmodule

// ===== rtl/init_command_list_parser_core.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// table in | input     | i_valid / o_stall  | i_table_byte[7:0]
// result   | output    | o_valid / i_stall  | o_kind[1:0] o_out_byte[7:0]
//          |           |                    | o_wait_ms[8:0] o_list_last
//
// One table byte is taken every cycle while the request queue has room; the
// parser state updates in that same cycle.
// A result is held in the queue, then in the output register, before it appears.
// Synchronous active-low reset returns the parser to waiting for a count byte.
// A stalled output fills the queue; o_stall rises only when the queue is full.
module init_command_list_parser_core #(
    parameter int QUEUE_DEPTH = iclp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_table_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [8:0] o_wait_ms,
    output logic       o_list_last
);
    import iclp_pkg::*;

    t_entry    push_entry;
    t_entry    head_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    iclp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_table_byte (i_table_byte),
        .i_q_status   (q_status),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    iclp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    iclp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_q_status  (q_status),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_wait_ms   (o_wait_ms),
        .o_list_last (o_list_last)
    );

endmodule
